// ===== sv/fbr_pkg.sv =====
// ----------------------------------------------------------------------------
// fbr_pkg: shared types and constants for the framed block receiver
// Parse phases, event codes, frame byte values and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package fbr_pkg;

  // Frame byte values
  localparam logic [7:0] BYTE_HEADER  = 8'h55;
  localparam logic [7:0] BYTE_SYNC    = 8'h3C;
  localparam logic [7:0] BYTE_TYPE    = 8'h01;
  localparam logic [7:0] BYTE_TRAILER = 8'h55;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_SYNC    = 3'd1,
    PH_TYPE    = 3'd2,
    PH_LEN_LO  = 3'd3,
    PH_LEN_HI  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6,
    PH_TRAILER = 3'd7
  } fbr_phase_t;

  // Result event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PAYLOAD = 2'd1,
    EV_END     = 2'd2,
    EV_BADTYPE = 2'd3
  } fbr_event_t;

  // One result item
  typedef struct packed {
    fbr_event_t  event_kind;
    logic [7:0]  payload_byte;
    logic        checksum_ok;
    logic        trailer_ok;
    logic [15:0] frame_length;
  } fbr_result_t;

endpackage : fbr_pkg

`default_nettype wire

// ===== sv/fbr_parser.sv =====
// ----------------------------------------------------------------------------
// fbr_parser: frame parse state machine
// Holds the parse phase, length, byte count and running sum; produces the
// result for the byte presented on rx_byte in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fbr_parser
  import fbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step_en,
  input  wire logic [7:0]  rx_byte,
  output fbr_result_t      result
);

  fbr_phase_t  phase_r,       phase_nxt;
  logic [7:0]  len_lo_r,      len_lo_nxt;
  logic [15:0] frame_size_r,  frame_size_nxt;
  logic [15:0] bytes_left_r,  bytes_left_nxt;
  logic [7:0]  run_sum_r,     run_sum_nxt;
  logic        sum_match_r,   sum_match_nxt;
  logic [15:0] new_size;

  assign new_size = {rx_byte, len_lo_r};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HEADER:  if (rx_byte == BYTE_HEADER) phase_nxt = PH_SYNC;
      PH_SYNC:    if (rx_byte == BYTE_SYNC) phase_nxt = PH_TYPE;
      PH_TYPE:    phase_nxt = (rx_byte == BYTE_TYPE) ? PH_LEN_LO : PH_HEADER;
      PH_LEN_LO:  phase_nxt = PH_LEN_HI;
      PH_LEN_HI:  phase_nxt = (new_size == '0) ? PH_CHECK : PH_PAYLOAD;
      PH_PAYLOAD: if (bytes_left_r == 16'd1) phase_nxt = PH_CHECK;
      PH_CHECK:   phase_nxt = PH_TRAILER;
      PH_TRAILER: phase_nxt = PH_HEADER;
      default:    phase_nxt = PH_HEADER;
    endcase
  end

  // Datapath state updates
  always_comb begin
    len_lo_nxt     = len_lo_r;
    frame_size_nxt = frame_size_r;
    bytes_left_nxt = bytes_left_r;
    run_sum_nxt    = run_sum_r;
    sum_match_nxt  = sum_match_r;
    case (phase_r)
      PH_LEN_LO: len_lo_nxt = rx_byte;
      PH_LEN_HI: begin
        frame_size_nxt = new_size;
        bytes_left_nxt = new_size;
        run_sum_nxt    = '0;
      end
      PH_PAYLOAD: begin
        run_sum_nxt    = run_sum_r + rx_byte;
        bytes_left_nxt = bytes_left_r - 16'd1;
      end
      PH_CHECK:  sum_match_nxt = (rx_byte == run_sum_r);
      default:   ;
    endcase
  end

  // Result for the current byte
  always_comb begin
    result = '{event_kind: EV_NONE, payload_byte: '0, checksum_ok: 1'b0,
               trailer_ok: 1'b0, frame_length: '0};
    case (phase_r)
      PH_TYPE: if (rx_byte != BYTE_TYPE) result.event_kind = EV_BADTYPE;
      PH_PAYLOAD: begin
        result.event_kind   = EV_PAYLOAD;
        result.payload_byte = rx_byte;
      end
      PH_TRAILER: begin
        result.event_kind   = EV_END;
        result.checksum_ok  = sum_match_r;
        result.trailer_ok   = (rx_byte == BYTE_TRAILER);
        result.frame_length = frame_size_r;
      end
      default: ;
    endcase
  end

  // State registers advance once per transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HEADER;
      len_lo_r     <= '0;
      frame_size_r <= '0;
      bytes_left_r <= '0;
      run_sum_r    <= '0;
      sum_match_r  <= 1'b0;
    end else if (step_en) begin
      phase_r      <= phase_nxt;
      len_lo_r     <= len_lo_nxt;
      frame_size_r <= frame_size_nxt;
      bytes_left_r <= bytes_left_nxt;
      run_sum_r    <= run_sum_nxt;
      sum_match_r  <= sum_match_nxt;
    end
  end

endmodule : fbr_parser

`default_nettype wire

// ===== sv/fbr_out_stage.sv =====
// ----------------------------------------------------------------------------
// fbr_out_stage: result register
// Holds one result until the downstream side takes it; accepts a new one
// in the same cycle the held one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module fbr_out_stage
  import fbr_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  load,
  input  wire fbr_result_t load_data,
  input  wire logic  out_ready,
  output logic       out_valid,
  output logic       can_load,
  output fbr_result_t out_data
);

  logic        valid_r;
  fbr_result_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  // Valid flag: set on load, cleared when the held result transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule : fbr_out_stage

`default_nettype wire

// ===== sv/framed_block_receiver_top.sv =====
// ----------------------------------------------------------------------------
// framed_block_receiver_top: byte-serial frame parser with additive checksum
// Hunts header/sync, checks type, reads a little-endian length, passes the
// payload out and reports checksum and trailer status at frame end.
// ----------------------------------------------------------------------------
// The result is registered: it is valid in the cycle after its input transfer.
// Throughput: one byte per cycle while in_ready is high; the parse state updates once per transfer.
// in_ready drops only while a result is held and out_ready is low.
// Reset (rst_n low, synchronous): parser returns to header hunt, no result held.
`default_nettype none

module framed_block_receiver_top
  import fbr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_payload_byte,
  output logic             out_checksum_ok,
  output logic             out_trailer_ok,
  output logic [15:0]      out_frame_length
);

  logic        in_xfer;
  fbr_result_t step_res;
  fbr_result_t held_res;

  assign in_xfer = in_valid && in_ready;

  // Parse state machine
  fbr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (in_xfer),
    .rx_byte (in_rx_byte),
    .result  (step_res)
  );

  // Result register
  fbr_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_xfer),
    .load_data (step_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .can_load  (in_ready),
    .out_data  (held_res)
  );

  assign out_event_kind   = held_res.event_kind;
  assign out_payload_byte = held_res.payload_byte;
  assign out_checksum_ok  = held_res.checksum_ok;
  assign out_trailer_ok   = held_res.trailer_ok;
  assign out_frame_length = held_res.frame_length;

  // An input transfer always yields a result next cycle
  a_xfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> out_valid)
    else $error("input transfer produced no result");

  // Frame-end fields are zero on every other event
  a_end_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != EV_END) |->
      (out_frame_length == 16'd0 && !out_checksum_ok && !out_trailer_ok))
    else $error("frame-end fields set outside frame end");

  // Payload byte is zero unless a payload event
  a_payload_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_event_kind != EV_PAYLOAD) |-> (out_payload_byte == 8'd0))
    else $error("payload byte set outside payload event");

  // Nothing held right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule : framed_block_receiver_top

`default_nettype wire
